// ----- sv/assert_macros.svh -----
// assertion macros shared by the vector alu modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define V3A_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// expression must never be true outside reset
`define V3A_NEVER(label, expr, msg) `V3A_ASSERT(label, !(expr), msg)

`endif

// ----- sv/v3a_pkg.sv -----
// types, codes and helper functions of the vector alu
`timescale 1ns / 1ps
package v3a_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned ROOT_STEPS  = 32;
   localparam int unsigned QUO_BITS    = 48;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_SCALE = 4'd2;
   localparam logic [3:0] OP_MUL   = 4'd3;
   localparam logic [3:0] OP_DIV   = 4'd4;
   localparam logic [3:0] OP_NEG   = 4'd5;
   localparam logic [3:0] OP_DOT   = 4'd6;
   localparam logic [3:0] OP_CROSS = 4'd7;
   localparam logic [3:0] OP_MAGSQ = 4'd8;
   localparam logic [3:0] OP_MAG   = 4'd9;
   localparam logic [3:0] OP_NORM  = 4'd10;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;
   localparam logic [1:0] ST_SAT  = 2'd3;

   typedef struct packed {
      logic [3:0]          op;
      logic signed [31:0]  a_x;
      logic signed [31:0]  a_y;
      logic signed [31:0]  a_z;
      logic signed [31:0]  b_x;
      logic signed [31:0]  b_y;
      logic signed [31:0]  b_z;
      logic signed [31:0]  scalar;
   } v3a_req_type;

   typedef struct packed {
      logic signed [31:0]  res_x;
      logic signed [31:0]  res_y;
      logic signed [31:0]  res_z;
      logic signed [31:0]  res_scalar;
      logic [1:0]          status;
   } v3a_rsp_type;

   typedef struct packed {
      v3a_req_type req;
      logic        is_iter;
   } v3a_item_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               hit;
   } v3a_sat_type;

   function automatic v3a_sat_type sat32(input logic signed [65:0] v);
      v3a_sat_type r;
      r.hit = 1'b1;
      if (v > 66'sd2147483647) begin
         r.value = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r.value = 32'sh80000000;
      end else begin
         r.value = v[31:0];
         r.hit   = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

endpackage

// ----- sv/vector3_alu_unit.sv -----
// three-component q16.16 vector alu top level
// add, sub, neg, scale, mul, dot, cross, magsq and special cases use the single-pass path;
// div, mag and normalize use the iterative unit (normalize runs sqrt then divide)
// throughput: one transaction per cycle on single-pass ops while the iterative unit idles;
// an iterative op holds the back end for its whole run (32 root steps, 48 quotient bits);
// the queue accepts until full; synchronous reset empties it and idles both back ends
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vector3_alu_unit #(
   parameter int unsigned QueueDepth = v3a_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  v3a_pkg::v3a_req_type  req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output v3a_pkg::v3a_rsp_type  rsp_data
);
   // queue head and back end handshake
   v3a_pkg::v3a_item_type item;
   logic item_valid;
   logic pop;
   logic fast_in_valid;
   logic iter_launch;
   logic iter_ready;
   logic iter_done;
   logic fast_valid;
   v3a_pkg::v3a_rsp_type fast_rsp;
   v3a_pkg::v3a_rsp_type iter_rsp;

   // output register, one strobe per transaction
   logic rsp_valid_ff, rsp_valid_in;
   v3a_pkg::v3a_rsp_type rsp_data_ff, rsp_data_in;

   // pop only while the iterative unit is idle, so results leave in order:
   // single-pass ops popped earlier drain long before any iterative result
   assign pop           = item_valid && iter_ready;
   assign fast_in_valid = pop && !item.is_iter;
   assign iter_launch   = pop && item.is_iter;

   v3a_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .pop        (pop),
      .item_valid (item_valid),
      .item       (item)
   );

   v3a_fast u_fast (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fast_in_valid),
      .req       (item.req),
      .out_valid (fast_valid),
      .out_rsp   (fast_rsp)
   );

   v3a_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .launch (iter_launch),
      .req    (item.req),
      .ready  (iter_ready),
      .done   (iter_done),
      .rsp    (iter_rsp)
   );

   // merge the two result sources, never both in one cycle
   always_comb begin
      rsp_valid_in = fast_valid || iter_done;
      rsp_data_in  = fast_valid ? fast_rsp : iter_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `V3A_NEVER(a_one_source, fast_valid && iter_done, "fast and iterative results collide")
endmodule

// ----- sv/v3a_front.sv -----
// front end: accepts transactions, classifies them and queues them
`timescale 1ns / 1ps
`include "assert_macros.svh"
module v3a_front #(
   parameter int unsigned Depth = v3a_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  v3a_pkg::v3a_req_type  req_data,
   output logic                  busy,
   input  logic                  pop,
   output logic                  item_valid,
   output v3a_pkg::v3a_item_type item
);
   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   v3a_pkg::v3a_item_type queue_ff [Depth];
   v3a_pkg::v3a_item_type entry_in;
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic push, do_pop, s_zero, a_zero;

   assign busy       = (count_ff == CntW'(Depth));
   assign item_valid = (count_ff != '0);
   assign push       = start && !busy;
   assign do_pop     = pop && item_valid;
   assign item       = queue_ff[rd_ptr_ff];

   // divide by a nonzero scalar, magnitude and nonzero normalize need the iterative unit
   always_comb begin
      s_zero         = (req_data.scalar == '0);
      a_zero         = (req_data.a_x == '0) && (req_data.a_y == '0) && (req_data.a_z == '0);
      entry_in.req   = req_data;
      entry_in.is_iter = ((req_data.op == v3a_pkg::OP_DIV) && !s_zero) ||
                         (req_data.op == v3a_pkg::OP_MAG) ||
                         ((req_data.op == v3a_pkg::OP_NORM) && !a_zero);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `V3A_ASSERT(a_count_bound, count_ff <= CntW'(Depth), "queue count above depth")
endmodule

// ----- sv/v3a_fast.sv -----
// single-pass datapath: add, sub, neg, products, dot, cross and special cases
`timescale 1ns / 1ps
module v3a_fast (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  v3a_pkg::v3a_req_type  req,
   output logic                  out_valid,
   output v3a_pkg::v3a_rsp_type  out_rsp
);
   logic signed [31:0] a [3];
   logic signed [31:0] b [3];
   logic signed [31:0] lhs [3];
   logic signed [31:0] rhs [3];
   logic signed [31:0] ql [3];
   logic signed [31:0] qr [3];
   logic signed [63:0] p_in [3];
   logic signed [63:0] q_in [3];
   logic signed [63:0] p_ff [3];
   logic signed [63:0] q_ff [3];
   logic signed [32:0] lin_in [3];
   logic signed [32:0] lin_ff [3];
   logic [3:0]         op_ff;
   logic               valid_ff;

   logic signed [65:0] rnd [3];
   logic signed [65:0] srnd;
   v3a_pkg::v3a_sat_type vsat [3];
   v3a_pkg::v3a_sat_type lsat [3];
   v3a_pkg::v3a_sat_type ssat;
   logic hit;

   // stage one: operand select, products and linear results
   always_comb begin
      a[0] = req.a_x; a[1] = req.a_y; a[2] = req.a_z;
      b[0] = req.b_x; b[1] = req.b_y; b[2] = req.b_z;
      for (int i = 0; i < 3; i++) begin
         lhs[i]    = '0;
         rhs[i]    = '0;
         ql[i]     = '0;
         qr[i]     = '0;
         lin_in[i] = '0;
      end
      case (req.op)
         v3a_pkg::OP_ADD: begin
            for (int i = 0; i < 3; i++) lin_in[i] = 33'(a[i]) + 33'(b[i]);
         end
         v3a_pkg::OP_SUB: begin
            for (int i = 0; i < 3; i++) lin_in[i] = 33'(a[i]) - 33'(b[i]);
         end
         v3a_pkg::OP_NEG: begin
            for (int i = 0; i < 3; i++) lin_in[i] = -33'(a[i]);
         end
         v3a_pkg::OP_DIV: begin
            for (int i = 0; i < 3; i++) lin_in[i] = 33'(a[i]);
         end
         v3a_pkg::OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               lhs[i] = a[i];
               rhs[i] = req.scalar;
            end
         end
         v3a_pkg::OP_MUL, v3a_pkg::OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               lhs[i] = a[i];
               rhs[i] = b[i];
            end
         end
         v3a_pkg::OP_MAGSQ: begin
            for (int i = 0; i < 3; i++) begin
               lhs[i] = a[i];
               rhs[i] = a[i];
            end
         end
         v3a_pkg::OP_CROSS: begin
            lhs[0] = a[1]; rhs[0] = b[2]; ql[0] = a[2]; qr[0] = b[1];
            lhs[1] = a[2]; rhs[1] = b[0]; ql[1] = a[0]; qr[1] = b[2];
            lhs[2] = a[0]; rhs[2] = b[1]; ql[2] = a[1]; qr[2] = b[0];
         end
         default: begin
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         p_in[i] = 64'(lhs[i]) * 64'(rhs[i]);
         q_in[i] = 64'(ql[i]) * 64'(qr[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= req.op;
      for (int i = 0; i < 3; i++) begin
         p_ff[i]   <= p_in[i];
         q_ff[i]   <= q_in[i];
         lin_ff[i] <= lin_in[i];
      end
   end

   // stage two: round to nearest with ties up, saturate, pick the result
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd[i]  = (66'(p_ff[i]) - 66'(q_ff[i]) + 66'sd32768) >>> 16;
         vsat[i] = v3a_pkg::sat32(rnd[i]);
         lsat[i] = v3a_pkg::sat32(66'(lin_ff[i]));
      end
      srnd = (66'(p_ff[0]) + 66'(p_ff[1]) + 66'(p_ff[2]) + 66'sd32768) >>> 16;
      ssat = v3a_pkg::sat32(srnd);
      out_rsp = '0;
      hit     = 1'b0;
      case (op_ff)
         v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_NEG: begin
            out_rsp.res_x = lsat[0].value;
            out_rsp.res_y = lsat[1].value;
            out_rsp.res_z = lsat[2].value;
            hit = lsat[0].hit || lsat[1].hit || lsat[2].hit;
         end
         v3a_pkg::OP_DIV: begin
            out_rsp.res_x  = lin_ff[0][31:0];
            out_rsp.res_y  = lin_ff[1][31:0];
            out_rsp.res_z  = lin_ff[2][31:0];
            out_rsp.status = v3a_pkg::ST_DIV0;
         end
         v3a_pkg::OP_SCALE, v3a_pkg::OP_MUL, v3a_pkg::OP_CROSS: begin
            out_rsp.res_x = vsat[0].value;
            out_rsp.res_y = vsat[1].value;
            out_rsp.res_z = vsat[2].value;
            hit = vsat[0].hit || vsat[1].hit || vsat[2].hit;
         end
         v3a_pkg::OP_DOT, v3a_pkg::OP_MAGSQ: begin
            out_rsp.res_scalar = ssat.value;
            hit = ssat.hit;
         end
         v3a_pkg::OP_NORM: begin
            out_rsp.status = v3a_pkg::ST_ZERO;
         end
         default: begin
         end
      endcase
      if (out_rsp.status == v3a_pkg::ST_OK && hit) begin
         out_rsp.status = v3a_pkg::ST_SAT;
      end
   end

   assign out_valid = valid_ff;
endmodule

// ----- sv/v3a_iter.sv -----
// iterative unit: square root for magnitude and restoring divide
`timescale 1ns / 1ps
`include "assert_macros.svh"
module v3a_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  launch,
   input  v3a_pkg::v3a_req_type  req,
   output logic                  ready,
   output logic                  done,
   output v3a_pkg::v3a_rsp_type  rsp
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SQR  = 4'd1;
   localparam logic [3:0] S_SUM  = 4'd2;
   localparam logic [3:0] S_ROOT = 4'd3;
   localparam logic [3:0] S_RFIN = 4'd4;
   localparam logic [3:0] S_DSET = 4'd5;
   localparam logic [3:0] S_DIV  = 4'd6;
   localparam logic [3:0] S_DFIN = 4'd7;
   localparam logic [3:0] S_DONE = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  op_ff, op_in;
   logic signed [31:0] a_ff [3];
   logic signed [31:0] a_in [3];
   logic [32:0] den_ff, den_in;
   logic        dneg_ff, dneg_in;
   logic [63:0] sqa_ff [3];
   logic [63:0] sqa_in [3];
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] num_ff [3];
   logic [47:0] num_in [3];
   logic [32:0] drem_ff [3];
   logic [32:0] drem_in [3];
   logic [47:0] quo_ff [3];
   logic [47:0] quo_in [3];
   v3a_pkg::v3a_rsp_type res_ff, res_in;

   logic [35:0] rem2, trial;
   logic [33:0] dtry [3];
   logic [32:0] mag;
   logic signed [65:0] qv [3];
   v3a_pkg::v3a_sat_type qs [3];
   v3a_pkg::v3a_sat_type ms;

   assign ready = (state_ff == S_IDLE);
   assign done  = (state_ff == S_DONE);
   assign rsp   = res_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      den_in   = den_ff;
      dneg_in  = dneg_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      for (int i = 0; i < 3; i++) begin
         a_in[i]    = a_ff[i];
         sqa_in[i]  = sqa_ff[i];
         num_in[i]  = num_ff[i];
         drem_in[i] = drem_ff[i];
         quo_in[i]  = quo_ff[i];
      end
      rem2  = {rem_ff, rad_ff[63:62]};
      trial = {2'b00, root_ff, 2'b01};
      mag   = 33'(root_ff) + 33'((rem_ff > 34'(root_ff)) ? 1'b1 : 1'b0);
      ms    = v3a_pkg::sat32(66'(mag));
      for (int i = 0; i < 3; i++) begin
         dtry[i] = {drem_ff[i], num_ff[i][47]};
         qv[i]   = (a_ff[i][31] ^ dneg_ff) ? -66'(quo_ff[i]) : 66'(quo_ff[i]);
         qs[i]   = v3a_pkg::sat32(qv[i]);
      end

      case (state_ff)
         S_IDLE: begin
            if (launch) begin
               op_in   = req.op;
               a_in[0] = req.a_x;
               a_in[1] = req.a_y;
               a_in[2] = req.a_z;
               den_in  = 33'(v3a_pkg::abs32(req.scalar));
               dneg_in = req.scalar[31];
               state_in = (req.op == v3a_pkg::OP_DIV) ? S_DSET : S_SQR;
            end
         end
         S_SQR: begin
            for (int i = 0; i < 3; i++) begin
               sqa_in[i] = 64'(v3a_pkg::abs32(a_ff[i])) * 64'(v3a_pkg::abs32(a_ff[i]));
            end
            state_in = S_SUM;
         end
         S_SUM: begin
            rad_in   = sqa_ff[0] + sqa_ff[1] + sqa_ff[2];
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            // two radicand bits per step
            if (rem2 >= trial) begin
               rem_in  = 34'(rem2 - trial);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = rem2[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in = {rad_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(v3a_pkg::ROOT_STEPS - 1)) begin
               state_in = S_RFIN;
            end
         end
         S_RFIN: begin
            if (op_ff == v3a_pkg::OP_MAG) begin
               res_in            = '0;
               res_in.res_scalar = ms.value;
               res_in.status     = ms.hit ? v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
               state_in          = S_DONE;
            end else begin
               den_in   = mag;
               dneg_in  = 1'b0;
               state_in = S_DSET;
            end
         end
         S_DSET: begin
            // numerator carries half the divisor for round to nearest
            for (int i = 0; i < 3; i++) begin
               num_in[i]  = (48'(v3a_pkg::abs32(a_ff[i])) << 16) + 48'(den_ff >> 1);
               drem_in[i] = '0;
               quo_in[i]  = '0;
            end
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int i = 0; i < 3; i++) begin
               if (dtry[i] >= {1'b0, den_ff}) begin
                  drem_in[i] = 33'(dtry[i] - {1'b0, den_ff});
                  quo_in[i]  = {quo_ff[i][46:0], 1'b1};
               end else begin
                  drem_in[i] = dtry[i][32:0];
                  quo_in[i]  = {quo_ff[i][46:0], 1'b0};
               end
               num_in[i] = {num_ff[i][46:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(v3a_pkg::QUO_BITS - 1)) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            res_in        = '0;
            res_in.res_x  = qs[0].value;
            res_in.res_y  = qs[1].value;
            res_in.res_z  = qs[2].value;
            res_in.status = (qs[0].hit || qs[1].hit || qs[2].hit) ?
                            v3a_pkg::ST_SAT : v3a_pkg::ST_OK;
            state_in      = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      den_ff  <= den_in;
      dneg_ff <= dneg_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      for (int i = 0; i < 3; i++) begin
         a_ff[i]    <= a_in[i];
         sqa_ff[i]  <= sqa_in[i];
         num_ff[i]  <= num_in[i];
         drem_ff[i] <= drem_in[i];
         quo_ff[i]  <= quo_in[i];
      end
   end

   `V3A_ASSERT(a_done_then_idle, done |=> ready, "iterative unit not idle after done")
   `V3A_NEVER(a_launch_busy, launch && !ready, "launch while iterative unit busy")
endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for the three-component q16.16 vector alu
`timescale 1ns / 1ps
module tb_top;

   logic                 clock;
   logic                 reset;
   logic                 start;
   v3a_pkg::v3a_req_type req_data;
   logic                 busy;
   logic                 rsp_valid;
   v3a_pkg::v3a_rsp_type rsp_data;

   v3a_pkg::v3a_rsp_type expected_rsp_q[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   bit          quiet_mode;   // no idle cycles on the request side

   vector3_alu_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .busy     (busy),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // watchdog on total cycles
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // report one mismatch and count it
   task automatic report_error(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   // saturate a wide value to 32 bits, flag overflow
   function automatic logic [31:0] clamp32(input logic signed [131:0] v, inout bit hit);
      if (v > 132'sd2147483647) begin
         hit = 1;
         return 32'h7FFFFFFF;
      end
      if (v < -132'sd2147483648) begin
         hit = 1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // sum of q32.32 products rounded at bit 16, ties toward +inf (arith shift is floor)
   function automatic logic [31:0] round_products(input logic signed [131:0] sum,
                                                  inout bit hit);
      logic signed [131:0] r;
      r = (sum + 132'sd32768) >>> 16;
      return clamp32(r, hit);
   endfunction

   // quotient a*65536/d rounded to nearest, ties away from zero
   function automatic logic [31:0] div_round(input logic signed [63:0] a,
                                             input logic signed [63:0] d, inout bit hit);
      logic [127:0]        num;
      logic [127:0]        den;
      logic signed [131:0] q;
      bit                  neg;
      neg = (a < 0) != (d < 0);
      num = (a < 0 ? -a : a);
      num = num << 16;
      den = (d < 0 ? -d : d);
      q   = $signed({4'b0, (num + den / 2) / den});
      return clamp32(neg ? -q : q, hit);
   endfunction

   // integer square root rounded to nearest
   function automatic logic [63:0] root_round(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] rem;
      logic [63:0] b;
      r   = 0;
      rem = n;
      b   = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (rem > r) r += 1;
      return r;
   endfunction

   // predicted response of the alu for one request
   function automatic v3a_pkg::v3a_rsp_type vector_alu_result(input v3a_pkg::v3a_req_type q);
      v3a_pkg::v3a_rsp_type o;
      logic signed [131:0] a[3];
      logic signed [131:0] b[3];
      logic signed [131:0] s;
      logic signed [131:0] acc;
      logic [63:0]         sq;
      logic [63:0]         m;
      bit                  hit;
      o    = '0;
      hit  = 0;
      a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z;
      b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
      s    = q.scalar;
      case (q.op)
         v3a_pkg::OP_ADD: begin
            o.res_x = clamp32(a[0] + b[0], hit);
            o.res_y = clamp32(a[1] + b[1], hit);
            o.res_z = clamp32(a[2] + b[2], hit);
         end
         v3a_pkg::OP_SUB: begin
            o.res_x = clamp32(a[0] - b[0], hit);
            o.res_y = clamp32(a[1] - b[1], hit);
            o.res_z = clamp32(a[2] - b[2], hit);
         end
         v3a_pkg::OP_SCALE: begin
            o.res_x = round_products(a[0] * s, hit);
            o.res_y = round_products(a[1] * s, hit);
            o.res_z = round_products(a[2] * s, hit);
         end
         v3a_pkg::OP_MUL: begin
            o.res_x = round_products(a[0] * b[0], hit);
            o.res_y = round_products(a[1] * b[1], hit);
            o.res_z = round_products(a[2] * b[2], hit);
         end
         v3a_pkg::OP_DIV: begin
            if (q.scalar == 0) begin
               o.res_x  = q.a_x;
               o.res_y  = q.a_y;
               o.res_z  = q.a_z;
               o.status = v3a_pkg::ST_DIV0;
            end else begin
               o.res_x = div_round(q.a_x, q.scalar, hit);
               o.res_y = div_round(q.a_y, q.scalar, hit);
               o.res_z = div_round(q.a_z, q.scalar, hit);
            end
         end
         v3a_pkg::OP_NEG: begin
            o.res_x = clamp32(-a[0], hit);
            o.res_y = clamp32(-a[1], hit);
            o.res_z = clamp32(-a[2], hit);
         end
         v3a_pkg::OP_DOT: begin
            acc = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            o.res_scalar = round_products(acc, hit);
         end
         v3a_pkg::OP_CROSS: begin
            o.res_x = round_products(a[1] * b[2] - a[2] * b[1], hit);
            o.res_y = round_products(a[2] * b[0] - a[0] * b[2], hit);
            o.res_z = round_products(a[0] * b[1] - a[1] * b[0], hit);
         end
         v3a_pkg::OP_MAGSQ: begin
            acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            o.res_scalar = round_products(acc, hit);
         end
         v3a_pkg::OP_MAG, v3a_pkg::OP_NORM: begin
            // the sum of squares wraps at 64 bits as in the reference arithmetic
            acc = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            sq  = acc[63:0];
            m   = root_round(sq);
            if (q.op == v3a_pkg::OP_MAG) begin
               o.res_scalar = clamp32($signed({68'b0, m}), hit);
            end else if (sq == 0) begin
               o.status = v3a_pkg::ST_ZERO;
            end else begin
               o.res_x = div_round(q.a_x, $signed(m), hit);
               o.res_y = div_round(q.a_y, $signed(m), hit);
               o.res_z = div_round(q.a_z, $signed(m), hit);
            end
         end
         default: ;
      endcase
      if (o.status == v3a_pkg::ST_OK && hit) o.status = v3a_pkg::ST_SAT;
      return o;
   endfunction

   // send one transaction, with a random idle gap first unless in quiet mode
   task automatic send_request(input v3a_pkg::v3a_req_type q);
      if (!quiet_mode) begin
         while ($urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp_q.push_back(vector_alu_result(q));
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      v3a_pkg::v3a_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            report_error("response with no transaction outstanding");
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.res_x !== want.res_x)
               report_error($sformatf("res_x %h want %h", rsp_data.res_x, want.res_x));
            if (rsp_data.res_y !== want.res_y)
               report_error($sformatf("res_y %h want %h", rsp_data.res_y, want.res_y));
            if (rsp_data.res_z !== want.res_z)
               report_error($sformatf("res_z %h want %h", rsp_data.res_z, want.res_z));
            if (rsp_data.res_scalar !== want.res_scalar)
               report_error($sformatf("res_scalar %h want %h", rsp_data.res_scalar,
                                      want.res_scalar));
            if (rsp_data.status !== want.status)
               report_error($sformatf("status %0d want %0d", rsp_data.status, want.status));
         end
      end
   end

   // operand mix: full range, small magnitudes or extremes
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(5))
         0, 1:    return $urandom();
         2, 3:    return 32'($signed($urandom_range(1 << 20))) - 32'sd524288;
         4:       return $signed(32'($urandom_range(131072))) - 32'sd65536;
         default: begin
            case ($urandom_range(4))
               0:       return 32'h7FFFFFFF;
               1:       return 32'h80000000;
               2:       return 32'h0;
               3:       return 32'h00010000;
               default: return 32'hFFFF0000;
            endcase
         end
      endcase
   endfunction

   function automatic v3a_pkg::v3a_req_type random_request(input logic [3:0] op);
      v3a_pkg::v3a_req_type q;
      q.op     = op;
      q.a_x    = pick_operand();
      q.a_y    = pick_operand();
      q.a_z    = pick_operand();
      q.b_x    = pick_operand();
      q.b_y    = pick_operand();
      q.b_z    = pick_operand();
      q.scalar = pick_operand();
      return q;
   endfunction

   // each op with extreme operands, plus the named special cases
   task automatic test_directed();
      v3a_pkg::v3a_req_type q;
      for (int op = 0; op <= 15; op++) begin
         q = '{op: 4'(op), a_x: 32'h7FFFFFFF, a_y: 32'h80000000, a_z: 32'h00018000,
               b_x: 32'h80000000, b_y: 32'h7FFFFFFF, b_z: 32'hFFFF8000,
               scalar: 32'h00020000};
         send_request(q);
      end
      q = '{op: v3a_pkg::OP_DIV, a_x: 32'h00030000, a_y: 32'hFFFF0000, a_z: 32'h7FFFFFFF,
            b_x: 0, b_y: 0, b_z: 0, scalar: 0};
      send_request(q);
      q = '{op: v3a_pkg::OP_NORM, a_x: 0, a_y: 0, a_z: 0, b_x: 32'hFFFFFFFF,
            b_y: 32'hFFFFFFFF, b_z: 32'hFFFFFFFF, scalar: 32'hFFFFFFFF};
      send_request(q);
      q = '{op: v3a_pkg::OP_NEG, a_x: 32'h80000000, a_y: 1, a_z: 0, b_x: 0, b_y: 0, b_z: 0,
            scalar: 0};
      send_request(q);
      q = '{op: v3a_pkg::OP_DIV, a_x: 32'h7FFFFFFF, a_y: 32'h80000000, a_z: 32'h00008000,
            b_x: 0, b_y: 0, b_z: 0, scalar: 1};
      send_request(q);
      q = '{op: v3a_pkg::OP_SCALE, a_x: 1, a_y: 32'hFFFFFFFF, a_z: 32'h00008000,
            b_x: 0, b_y: 0, b_z: 0, scalar: 32'h00008000};
      send_request(q);
   endtask

   // random stream; mostly defined ops, a few unused codes
   task automatic test_random(input int count);
      logic [3:0] op;
      for (int i = 0; i < count; i++) begin
         quiet_mode = (i >= count / 2) && (i < count / 2 + 200);
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10));
         send_request(random_request(op));
      end
      quiet_mode = 0;
   endtask

   initial begin
      start       <= 1'b0;
      req_data    <= '0;
      reset       <= 1'b1;
      quiet_mode   = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1530);
      start <= 1'b0;
      // drain outstanding transactions, then settle
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
